[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rtc assertion failed");

// Checked on every rising edge, reset included.
`define RTC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rtc assertion failed");

`endif

[src/rtc_pkg.sv]
`default_nettype none

package rtc_pkg;

  localparam int WHITE_W   = 18;
  localparam int CFG_IDX_W = 2;
  localparam int LIN_W     = 17;
  localparam int COEF_W    = 20;
  localparam int PROD_W    = 37;
  localparam int SUM_W     = 37;
  localparam int NUM_W     = 45;
  localparam int DEN_W     = 22;
  localparam int ROOT_W    = 26;
  localparam int SQ_W      = 2 * ROOT_W - 16;
  localparam int LINM_W    = 24;
  localparam int LINQ_W    = 18;

  localparam logic [CFG_IDX_W-1:0] REG_WHITE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z = 2'd2;

  localparam logic [WHITE_W-1:0] WHITE_X_RST = 18'd95047;
  localparam logic [WHITE_W-1:0] WHITE_Y_RST = 18'd100000;
  localparam logic [WHITE_W-1:0] WHITE_Z_RST = 18'd108883;

  localparam logic [NUM_W-1:0]  THRESH_Q24   = 45'd148578;
  localparam logic [ROOT_W-1:0] LIN_OFFSET   = 26'd144631;
  localparam logic [LINQ_W-1:0] LIN_RECIP    = 18'd134218;

  localparam logic [0:2][0:2][COEF_W-1:0] MAT_COEF = '{
    '{20'd412453, 20'd357580, 20'd180423},
    '{20'd212671, 20'd715160, 20'd72169},
    '{20'd19334,  20'd119193, 20'd950227}
  };

  typedef logic [255:0][LIN_W-1:0] gamma_rom_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   sq;
    logic [NUM_W-1:0]  ratio;
    logic              sel;
    logic [LINM_W-1:0] lin_m;
    logic [LINQ_W-1:0] lin_q;
    logic [ROOT_W-1:0] lin_f;
  } cube_ch_t;

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t  rom;
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] p;
    rom = '0;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        rom[v] = LIN_W'((64'(v) * 64'd6553600 + 64'd164730) / 64'd329460);
      end else begin
        num = (64'(v) * 64'd1000 + 64'd14025) << 20;
        t   = (num + 64'd134512) / 64'd269025;
        t2  = (t * t) >> 20;
        r   = '0;
        for (int b = 20; b >= 0; b--) begin
          cand = r | (64'd1 << b);
          p    = cand;
          for (int k = 0; k < 4; k++) begin
            p = (p * cand) >> 20;
          end
          if (cand <= (64'd1 << 20) && p <= t2) begin
            r = cand;
          end
        end
        rom[v] = LIN_W'((((t2 * r) >> 20) + 64'd8) >> 4);
      end
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

`default_nettype wire

[src/rgb_to_cielab_pixel.sv]
`default_nettype none

// Converts one 8-bit sRGB pixel per clock into CIE L*, a* and b* with OUT_FRAC_BITS fraction
// bits, saturated. From acceptance to its result word a pixel passes the gamma table, the
// colour matrix and the scaling by the reference white, the bit-per-stage divider, the cube
// root (two stages per root bit) and the stages that form and round the outputs. One pixel
// enters every clock; while the result word is held back, the whole pipeline holds. The
// white registers must be written only while no pixel is in flight; this is not enforced.
module rgb_to_cielab_pixel #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rtc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rtc_pkg::WHITE_W-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [14:0]                        lightness_o,
  output logic signed [15:0]                 green_red_o,
  output logic signed [15:0]                 blue_yellow_o
);

  localparam int SHIFT   = 20 - OUT_FRAC_BITS;
  localparam int DIV_ST  = rtc_pkg::NUM_W;
  localparam int CUBE_ST = 2 * rtc_pkg::ROOT_W;
  localparam int NSTG    = 4 + DIV_ST + CUBE_ST + 2;
  localparam int OW      = 37;
  localparam int CW      = rtc_pkg::SQ_W + rtc_pkg::ROOT_W;
  localparam logic signed [OW-1:0] L_OFF = 37'sd16777216;
  localparam logic signed [OW-1:0] HALF  = OW'(1) << (SHIFT - 1);

  logic adv;
  logic [NSTG-1:0] vld_q;

  assign adv         = !vld_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  logic [rtc_pkg::WHITE_W-1:0] white_x_q, white_y_q, white_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_x_q <= rtc_pkg::WHITE_X_RST;
      white_y_q <= rtc_pkg::WHITE_Y_RST;
      white_z_q <= rtc_pkg::WHITE_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtc_pkg::REG_WHITE_X: white_x_q <= cfg_data_i;
        rtc_pkg::REG_WHITE_Y: white_y_q <= cfg_data_i;
        rtc_pkg::REG_WHITE_Z: white_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [2:0][rtc_pkg::LIN_W-1:0]            lin_q;
  logic [2:0][2:0][rtc_pkg::PROD_W-1:0]      prod_q;
  logic [2:0][rtc_pkg::SUM_W-1:0]            sum_q;
  logic [2:0][rtc_pkg::NUM_W-1:0]            num_q;
  logic [2:0][rtc_pkg::DEN_W-1:0]            den_q;
  logic [2:0][rtc_pkg::WHITE_W-1:0]          white_eff;
  logic [2:0][rtc_pkg::WHITE_W-1:0]          white_raw;

  assign white_raw = {white_z_q, white_y_q, white_x_q};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      white_eff[c] = (white_raw[c] == '0) ? rtc_pkg::WHITE_W'(1) : white_raw[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_q[0] <= rtc_pkg::GAMMA_ROM[red_i];
      lin_q[1] <= rtc_pkg::GAMMA_ROM[green_i];
      lin_q[2] <= rtc_pkg::GAMMA_ROM[blue_i];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= rtc_pkg::PROD_W'(rtc_pkg::MAT_COEF[i][j])
                          * rtc_pkg::PROD_W'(lin_q[j]);
        end
        sum_q[i] <= prod_q[i][0] + prod_q[i][1] + prod_q[i][2];
        num_q[i] <= {sum_q[i], 8'd0} + rtc_pkg::NUM_W'(white_eff[i]) * 5;
        den_q[i] <= rtc_pkg::DEN_W'(rtc_pkg::DEN_W'(white_eff[i]) * 10);
      end
    end
  end

  logic [2:0][rtc_pkg::DEN_W-1:0] drem_q [DIV_ST];
  logic [2:0][rtc_pkg::DEN_W-1:0] dden_q [DIV_ST];
  logic [2:0][rtc_pkg::NUM_W-1:0] dnum_q [DIV_ST];
  logic [2:0][rtc_pkg::NUM_W-1:0] dquo_q [DIV_ST];

  for (genvar k = 0; k < DIV_ST; k++) begin : g_div
    logic [2:0][rtc_pkg::DEN_W-1:0] rem_in, den_in, rem_d;
    logic [2:0][rtc_pkg::NUM_W-1:0] num_in, quo_in;
    logic [2:0][rtc_pkg::DEN_W:0]   sh;
    logic [2:0]                     qb;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_q;
      assign num_in = num_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = drem_q[k-1];
      assign den_in = dden_q[k-1];
      assign num_in = dnum_q[k-1];
      assign quo_in = dquo_q[k-1];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        sh[c]    = {rem_in[c], num_in[c][rtc_pkg::NUM_W-1-k]};
        qb[c]    = sh[c] >= {1'b0, den_in[c]};
        rem_d[c] = qb[c] ? rtc_pkg::DEN_W'(sh[c] - {1'b0, den_in[c]})
                         : rtc_pkg::DEN_W'(sh[c]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        drem_q[k] <= rem_d;
        dden_q[k] <= den_in;
        dnum_q[k] <= num_in;
        for (int c = 0; c < 3; c++) begin
          dquo_q[k][c] <= {quo_in[c][rtc_pkg::NUM_W-2:0], qb[c]};
        end
      end
    end
  end

  rtc_pkg::cube_ch_t [2:0] cube_q [CUBE_ST];

  for (genvar t = 0; t < CUBE_ST; t++) begin : g_cube
    localparam int BIT = rtc_pkg::ROOT_W - 1 - t / 2;
    rtc_pkg::cube_ch_t [2:0]               cin, cout;
    logic [2:0][rtc_pkg::ROOT_W-1:0]       cand;
    logic [2:0][2*rtc_pkg::ROOT_W-1:0]     sq_full;
    logic [2:0][CW-1:0]                    cube_full;
    logic [2:0][30:0]                      lin_n;
    logic [2:0][2*rtc_pkg::LINM_W-7:0]     lin_p;
    logic [2:0][24:0]                      lin_back;

    if (t == 0) begin : g_first
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          cin[c]       = '0;
          cin[c].ratio = dquo_q[DIV_ST-1][c];
        end
      end
    end else begin : g_next
      assign cin = cube_q[t-1];
    end

    always_comb begin
      cout = cin;
      for (int c = 0; c < 3; c++) begin
        cand[c]      = cin[c].root | (rtc_pkg::ROOT_W'(1) << BIT);
        sq_full[c]   = (2*rtc_pkg::ROOT_W)'(cand[c]) * (2*rtc_pkg::ROOT_W)'(cand[c]);
        cube_full[c] = CW'(cin[c].sq) * CW'(cand[c]);
        lin_n[c]     = 31'(cin[c].ratio[17:0]) * 31'd7787 + 31'd8000;
        lin_p[c]     = 42'(cin[c].lin_m) * 42'(rtc_pkg::LIN_RECIP);
        lin_back[c]  = 25'(cin[c].lin_q) * 25'd125;
        if (t % 2 == 0) begin
          cout[c].sq = rtc_pkg::SQ_W'(sq_full[c] >> 16);
        end else if ((cube_full[c] >> 20) <= CW'(cin[c].ratio)) begin
          cout[c].root = cand[c];
        end
        if (t == 0) begin
          cout[c].sel   = cin[c].ratio > rtc_pkg::THRESH_Q24;
          cout[c].lin_m = rtc_pkg::LINM_W'(lin_n[c] >> 7);
        end
        if (t == 1) begin
          cout[c].lin_q = rtc_pkg::LINQ_W'(lin_p[c] >> 24);
        end
        if (t == 2) begin
          if (lin_back[c] > 25'(cin[c].lin_m)) begin
            cout[c].lin_f = rtc_pkg::ROOT_W'(cin[c].lin_q - 1'b1) + rtc_pkg::LIN_OFFSET;
          end else begin
            cout[c].lin_f = rtc_pkg::ROOT_W'(cin[c].lin_q) + rtc_pkg::LIN_OFFSET;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cube_q[t] <= cout;
      end
    end
  end

  logic [2:0][rtc_pkg::ROOT_W-1:0] f_val;
  logic signed [OW-1:0] fx_s, fy_s, fz_s;
  logic signed [OW-1:0] lv_q, av_q, bv_q;
  logic signed [OW-1:0] lw, aw, bw, lr, ar, br;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      f_val[c] = cube_q[CUBE_ST-1][c].sel ? cube_q[CUBE_ST-1][c].root
                                          : cube_q[CUBE_ST-1][c].lin_f;
    end
  end

  assign fx_s = signed'(OW'(f_val[0]));
  assign fy_s = signed'(OW'(f_val[1]));
  assign fz_s = signed'(OW'(f_val[2]));

  assign lw = lv_q + HALF;
  assign aw = av_q + HALF;
  assign bw = bv_q + HALF;
  assign lr = lw >>> SHIFT;
  assign ar = aw >>> SHIFT;
  assign br = bw >>> SHIFT;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lv_q <= fy_s * 116 - L_OFF;
      av_q <= (fx_s - fy_s) * 500;
      bv_q <= (fy_s - fz_s) * 200;
      if (lr < 0) begin
        lightness_o <= '0;
      end else if (lr > 37'sd32767) begin
        lightness_o <= 15'h7FFF;
      end else begin
        lightness_o <= lr[14:0];
      end
      if (ar < -37'sd32768) begin
        green_red_o <= 16'sh8000;
      end else if (ar > 37'sd32767) begin
        green_red_o <= 16'sh7FFF;
      end else begin
        green_red_o <= ar[15:0];
      end
      if (br < -37'sd32768) begin
        blue_yellow_o <= 16'sh8000;
      end else if (br > 37'sd32767) begin
        blue_yellow_o <= 16'sh7FFF;
      end else begin
        blue_yellow_o <= br[15:0];
      end
    end
  end

endmodule

`default_nettype wire

[src/rtc_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module rtc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [14:0]        lightness_o,
  input wire logic signed [15:0] green_red_o,
  input wire logic signed [15:0] blue_yellow_o
);

  logic [46:0] out_word;

  assign out_word = {lightness_o, green_red_o, blue_yellow_o};

  // The pipeline only ever holds because the result word is held back.
  `RTC_ASSERT(a_ready_follows_sink, out_ready_i |-> in_ready_o)
  `RTC_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)
  `RTC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)
  `RTC_ASSERT(a_word_held, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word))

endmodule

bind rgb_to_cielab_pixel rtc_checker u_rtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .lightness_o   (lightness_o),
  .green_red_o   (green_red_o),
  .blue_yellow_o (blue_yellow_o)
);

`default_nettype wire

[tb/rgb_to_cielab_pixel_tb.sv]
`default_nettype none

module rgb_to_cielab_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS     = 8;
  localparam int PIPE_LATENCY  = 103;
  localparam int WATCHDOG_MAX  = 20000;
  localparam logic [rtc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_word_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [rtc_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [rtc_pkg::WHITE_W-1:0]     cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [7:0]                      red_i = '0;
  logic [7:0]                      green_i = '0;
  logic [7:0]                      blue_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [14:0]                     lightness_o;
  logic signed [15:0]              green_red_o;
  logic signed [15:0]              blue_yellow_o;

  rgb_to_cielab_pixel #(.OUT_FRAC_BITS(FRAC_BITS)) DUT (.*);

  always #10 clk_i = ~clk_i;

  longint unsigned srgb_linear[256];
  logic [rtc_pkg::WHITE_W-1:0] white_ref[3];
  lab_word_t lab_expected[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned fifth_power(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) p = (p * r) >> 20;
    return p;
  endfunction

  function automatic void fill_linear_table();
    longint unsigned t, t2, r, cand;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        srgb_linear[v] = (longint'(v) * 6553600 + 164730) / 329460;
      end else begin
        t  = (((longint'(v) * 1000 + 14025) << 20) + 134512) / 269025;
        t2 = (t * t) >> 20;
        r  = 0;
        for (int b = 20; b >= 0; b--) begin
          cand = r | (64'd1 << b);
          if (cand <= (64'd1 << 20) && fifth_power(cand) <= t2) r = cand;
        end
        srgb_linear[v] = (((t2 * r) >> 20) + 8) >> 4;
      end
    end
  endfunction

  function automatic longint unsigned lab_curve(longint unsigned ratio);
    longint unsigned r, cand;
    if (ratio > 148578) begin
      r = 0;
      for (int b = 25; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if ((((cand * cand) >> 16) * cand) >> 20 <= ratio) r = cand;
      end
      return r;
    end
    return (7787 * ratio + 8000) / 16000 + 144631;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_word_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned lin[3], fv[3], sum, den, w;
    longint lv, av, bv;
    longint unsigned coef[3][3] = '{'{412453, 357580, 180423},
                                    '{212671, 715160, 72169},
                                    '{19334, 119193, 950227}};
    lab_word_t res;
    lin[0] = srgb_linear[r];
    lin[1] = srgb_linear[g];
    lin[2] = srgb_linear[b];
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) sum += coef[i][j] * lin[j];
      w     = (white_ref[i] == 0) ? 1 : white_ref[i];
      den   = 655360 * w;
      fv[i] = lab_curve(((sum << 24) + den / 2) / den);
    end
    lv = 116 * longint'(fv[1]) - (longint'(16) << 20);
    av = 500 * (longint'(fv[0]) - longint'(fv[1]));
    bv = 200 * (longint'(fv[1]) - longint'(fv[2]));
    lv = (lv + (longint'(1) << (19 - FRAC_BITS))) >>> (20 - FRAC_BITS);
    av = (av + (longint'(1) << (19 - FRAC_BITS))) >>> (20 - FRAC_BITS);
    bv = (bv + (longint'(1) << (19 - FRAC_BITS))) >>> (20 - FRAC_BITS);
    res.lightness   = 15'(clip(lv, 0, 32767));
    res.green_red   = 16'(clip(av, -32768, 32767));
    res.blue_yellow = 16'(clip(bv, -32768, 32767));
    return res;
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    lab_word_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
      if (in_valid_i && in_ready_o)
        lab_expected.push_back(convert_pixel(red_i, green_i, blue_i));
      if (out_valid_o && out_ready_i) begin
        if (lab_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word L=%0d a=%0d b=%0d",
                                         lightness_o, green_red_o, blue_yellow_o);
        end else begin
          want = lab_expected.pop_front();
          if (lightness_o !== want.lightness || green_red_o !== want.green_red ||
              blue_yellow_o !== want.blue_yellow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                       want.lightness, want.green_red, want.blue_yellow,
                       lightness_o, green_red_o, blue_yellow_o);
          end
        end
      end
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    red_i      = r;
    green_i    = g;
    blue_i     = b;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i = 1'b0;
    while (lab_expected.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic write_white(logic [rtc_pkg::CFG_IDX_W-1:0] idx,
                             logic [rtc_pkg::WHITE_W-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    if (idx <= rtc_pkg::REG_WHITE_Z) white_ref[idx] = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_corners();
    logic [7:0] levels[8] = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd128, 8'd170, 8'd254, 8'd255};
    foreach (levels[i]) send_pixel(levels[i], levels[i], levels[i]);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd85, 8'd170, 8'd85);
    send_pixel(8'd170, 8'd85, 8'd170);
  endtask

  task automatic test_default_white();
    send_corners();
    drain_pipeline();
  endtask

  task automatic test_white_extremes();
    write_white(rtc_pkg::REG_WHITE_X, '0);
    write_white(rtc_pkg::REG_WHITE_Y, 18'd1);
    write_white(rtc_pkg::REG_WHITE_Z, '1);
    send_corners();
    drain_pipeline();
    write_white(rtc_pkg::REG_WHITE_X, '1);
    write_white(rtc_pkg::REG_WHITE_Y, '1);
    write_white(rtc_pkg::REG_WHITE_Z, '0);
    write_white(REG_UNUSED, 18'd12345);
    send_corners();
    drain_pipeline();
  endtask

  task automatic test_random_pixels(int count, int idle_pct, int stall_pct);
    int kind;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      if (kind < 6) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      else if (kind < 8)
        send_pixel(8'($urandom_range(12)), 8'($urandom_range(12)),
                   8'($urandom_range(12)));
      else begin
        logic [7:0] grey;
        grey = 8'($urandom);
        send_pixel(grey, grey, grey);
      end
    end
    drain_pipeline();
  endtask

  initial begin
    fill_linear_table();
    white_ref[0] = rtc_pkg::WHITE_X_RST;
    white_ref[1] = rtc_pkg::WHITE_Y_RST;
    white_ref[2] = rtc_pkg::WHITE_Z_RST;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_default_white();
    test_white_extremes();
    write_white(rtc_pkg::REG_WHITE_X, rtc_pkg::WHITE_X_RST);
    write_white(rtc_pkg::REG_WHITE_Y, rtc_pkg::WHITE_Y_RST);
    write_white(rtc_pkg::REG_WHITE_Z, rtc_pkg::WHITE_Z_RST);
    test_random_pixels(500, 36, 69);
    write_white(rtc_pkg::REG_WHITE_X, 18'($urandom_range(262143)));
    write_white(rtc_pkg::REG_WHITE_Y, 18'($urandom_range(200000, 1)));
    write_white(rtc_pkg::REG_WHITE_Z, 18'($urandom_range(120000, 80000)));
    test_random_pixels(500, 69, 36);
    write_white(rtc_pkg::REG_WHITE_X, 18'd96422);
    write_white(rtc_pkg::REG_WHITE_Y, 18'd100000);
    write_white(rtc_pkg::REG_WHITE_Z, 18'd82521);
    test_random_pixels(500, 0, 0);
    write_white(rtc_pkg::REG_WHITE_X, 18'($urandom_range(262143)));
    write_white(rtc_pkg::REG_WHITE_Y, 18'($urandom_range(262143)));
    write_white(rtc_pkg::REG_WHITE_Z, 18'($urandom_range(262143)));
    test_random_pixels(400, 0, 0);
    if (mismatches == 0 && lab_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/rtc_pkg.sv
src/rgb_to_cielab_pixel.sv
src/rtc_checker.sv
tb/rgb_to_cielab_pixel_tb.sv
